// File: rtl/sps_pkg.sv
package sps_pkg;

  // default build of the search
  localparam int unsigned DEF_MAX_VERTICES = 65536;
  localparam int unsigned DEF_COORD_BITS   = 24;
  localparam int unsigned DEF_DIR_BITS     = 18;

  // lanes of the running argmax and width of the reported index
  localparam int unsigned LANES       = 4;
  localparam int unsigned LANE_BITS   = 2;
  localparam int unsigned INDEX_BITS  = 16;

endpackage

// File: rtl/sps_if.sv
// vertex request channel
interface sps_in_if import sps_pkg::*; #(
  parameter int unsigned DIR_BITS   = DEF_DIR_BITS,
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [DIR_BITS-1:0]   dir_x;
  logic signed [DIR_BITS-1:0]   dir_y;
  logic signed [DIR_BITS-1:0]   dir_z;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] vertex_z;
  logic                         last_vertex;

  modport source (
    output valid, dir_x, dir_y, dir_z, vertex_x, vertex_y, vertex_z, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, dir_x, dir_y, dir_z, vertex_x, vertex_y, vertex_z, last_vertex,
    output ready
  );
endinterface

// support point result channel
interface sps_out_if import sps_pkg::*; #(
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic [INDEX_BITS-1:0]        best_index;
  logic signed [COORD_BITS-1:0] best_x;
  logic signed [COORD_BITS-1:0] best_y;
  logic signed [COORD_BITS-1:0] best_z;

  modport source (
    output valid, best_index, best_x, best_y, best_z,
    input  ready
  );
  modport sink (
    input  valid, best_index, best_x, best_y, best_z,
    output ready
  );
endinterface

// File: rtl/support_point_search.sv
// Support point search: takes one mesh vertex per cycle together with a search
// direction and keeps, in four lanes (vertex i in lane i mod 4), the vertex with
// the largest exact dot product direction.vertex; within a lane the earliest
// maximum is kept, across lanes the lowest lane wins on a tie. The request
// flagged last_vertex closes the query and yields one result: index and
// coordinates of the winner. Vertices past MAX_VERTICES in a query are dropped,
// but their last_vertex flag still closes the query. Throughput is one vertex
// per cycle while input is not held off, set by the three multipliers and the
// single lane compare per cycle; the result is registered after the input,
// product, dot product, lane update, pair compare and final compare stages.
// Input is held off only when a finished result still waits at the output and
// the next one is ready to leave the final stage.
module support_point_search import sps_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned COORD_BITS   = DEF_COORD_BITS,
  parameter int unsigned DIR_BITS     = DEF_DIR_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  sps_in_if.sink    in_ch,
  sps_out_if.source out_ch
);

  localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_VERTICES);
  localparam int unsigned BLK_W  = (IDX_W > LANE_BITS) ? IDX_W - LANE_BITS : 1;
  localparam int unsigned PROD_W = DIR_BITS + COORD_BITS;
  localparam int unsigned DOT_W  = PROD_W + 2;

  typedef struct packed {
    logic                         fill;
    logic signed [DOT_W-1:0]      dot;
    logic [LANE_BITS-1:0]         lane;
    logic [BLK_W-1:0]             blk;
    logic [COORD_BITS-1:0]        x;
    logic [COORD_BITS-1:0]        y;
    logic [COORD_BITS-1:0]        z;
  } cand_t;

  // later candidate wins if the earlier one is empty, or if both are filled and it is strictly greater
  function automatic cand_t pick(input cand_t a, input cand_t b);
    cand_t r;
    if (!a.fill) begin
      r = b;
    end else if (!b.fill) begin
      r = a;
    end else if (b.dot > a.dot) begin
      r = b;
    end else begin
      r = a;
    end
    return r;
  endfunction

  logic adv;

  // query counter
  logic [CNT_W-1:0] cnt_r;
  logic             take;
  logic [CNT_W-1:0] cnt_sh;

  // input stage
  logic                         a_valid_r;
  logic                         a_take_r;
  logic                         a_last_r;
  logic [LANE_BITS-1:0]         a_lane_r;
  logic [BLK_W-1:0]             a_blk_r;
  logic signed [DIR_BITS-1:0]   a_dx_r, a_dy_r, a_dz_r;
  logic signed [COORD_BITS-1:0] a_vx_r, a_vy_r, a_vz_r;

  // product stage
  logic                         b_valid_r;
  logic                         b_take_r;
  logic                         b_last_r;
  logic [LANE_BITS-1:0]         b_lane_r;
  logic [BLK_W-1:0]             b_blk_r;
  logic signed [PROD_W-1:0]     b_px_r, b_py_r, b_pz_r;
  logic signed [COORD_BITS-1:0] b_vx_r, b_vy_r, b_vz_r;

  // dot product stage
  logic                         c_valid_r;
  logic                         c_take_r;
  logic                         c_last_r;
  logic [LANE_BITS-1:0]         c_lane_r;
  logic [BLK_W-1:0]             c_blk_r;
  logic signed [DOT_W-1:0]      c_dot_r;
  logic signed [DOT_W-1:0]      c_dot_nxt;
  logic signed [COORD_BITS-1:0] c_vx_r, c_vy_r, c_vz_r;

  // lane state
  logic [LANES-1:0]             lane_fill_r;
  logic [LANES-1:0]             lane_fill_nxt;
  logic signed [DOT_W-1:0]      lane_dot_r [LANES];
  logic [BLK_W-1:0]             lane_blk_r [LANES];
  logic [COORD_BITS-1:0]        lane_x_r   [LANES];
  logic [COORD_BITS-1:0]        lane_y_r   [LANES];
  logic [COORD_BITS-1:0]        lane_z_r   [LANES];
  logic                         upd;

  // end of query snapshot, pair compare and final compare
  logic                         d_valid_r;
  logic [LANES-1:0]             d_fill_r;
  cand_t                        lane_cand [LANES];
  logic                         e_valid_r;
  cand_t                        e_lo_r, e_hi_r;
  cand_t                        fin;
  logic [BLK_W+LANE_BITS+INDEX_BITS-1:0] idx_wide;

  // output register
  logic                         out_valid_r;
  logic [INDEX_BITS-1:0]        out_index_r;
  logic [COORD_BITS-1:0]        out_x_r, out_y_r, out_z_r;

  // pipeline moves unless a result would overwrite one still waiting
  assign adv         = !e_valid_r || !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign take   = (cnt_r < CNT_W'(MAX_VERTICES));
  assign cnt_sh = cnt_r >> LANE_BITS;

  // vertex counter per query
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_ch.valid && adv) begin
      if (in_ch.last_vertex) begin
        cnt_r <= '0;
      end else if (take) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_ch.valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r && c_last_r;
      e_valid_r <= d_valid_r;
    end
  end

  // input register, products, dot product
  assign c_dot_nxt = DOT_W'(b_px_r) + DOT_W'(b_py_r) + DOT_W'(b_pz_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_take_r <= take;
      a_last_r <= in_ch.last_vertex;
      a_lane_r <= cnt_r[LANE_BITS-1:0];
      a_blk_r  <= cnt_sh[BLK_W-1:0];
      a_dx_r   <= in_ch.dir_x;
      a_dy_r   <= in_ch.dir_y;
      a_dz_r   <= in_ch.dir_z;
      a_vx_r   <= in_ch.vertex_x;
      a_vy_r   <= in_ch.vertex_y;
      a_vz_r   <= in_ch.vertex_z;

      b_take_r <= a_take_r;
      b_last_r <= a_last_r;
      b_lane_r <= a_lane_r;
      b_blk_r  <= a_blk_r;
      b_px_r   <= a_dx_r * a_vx_r;
      b_py_r   <= a_dy_r * a_vy_r;
      b_pz_r   <= a_dz_r * a_vz_r;
      b_vx_r   <= a_vx_r;
      b_vy_r   <= a_vy_r;
      b_vz_r   <= a_vz_r;

      c_take_r <= b_take_r;
      c_last_r <= b_last_r;
      c_lane_r <= b_lane_r;
      c_blk_r  <= b_blk_r;
      c_dot_r  <= c_dot_nxt;
      c_vx_r   <= b_vx_r;
      c_vy_r   <= b_vy_r;
      c_vz_r   <= b_vz_r;
    end
  end

  // lane compare: empty lane or strictly greater dot takes the vertex
  assign upd = c_valid_r && c_take_r &&
               (!lane_fill_r[c_lane_r] || (c_dot_r > lane_dot_r[c_lane_r]));

  always_comb begin
    lane_fill_nxt = lane_fill_r;
    if (upd) begin
      lane_fill_nxt[c_lane_r] = 1'b1;
    end
  end

  // lane fill mask, cleared when the query closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_fill_r <= '0;
    end else if (adv && c_valid_r) begin
      if (c_last_r) begin
        lane_fill_r <= '0;
      end else begin
        lane_fill_r <= lane_fill_nxt;
      end
    end
  end

  // lane best payload and end of query fill snapshot
  always_ff @(posedge clk) begin
    if (adv) begin
      d_fill_r <= lane_fill_nxt;
      if (upd) begin
        lane_dot_r[c_lane_r] <= c_dot_r;
        lane_blk_r[c_lane_r] <= c_blk_r;
        lane_x_r[c_lane_r]   <= c_vx_r;
        lane_y_r[c_lane_r]   <= c_vy_r;
        lane_z_r[c_lane_r]   <= c_vz_r;
      end
    end
  end

  // lane candidates of the closed query
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_cand[i].fill = d_fill_r[i];
      lane_cand[i].dot  = lane_dot_r[i];
      lane_cand[i].lane = LANE_BITS'(i);
      lane_cand[i].blk  = lane_blk_r[i];
      lane_cand[i].x    = lane_x_r[i];
      lane_cand[i].y    = lane_y_r[i];
      lane_cand[i].z    = lane_z_r[i];
    end
  end

  // pair compare, lower lane kept on a tie
  always_ff @(posedge clk) begin
    if (adv) begin
      e_lo_r <= pick(lane_cand[0], lane_cand[1]);
      e_hi_r <= pick(lane_cand[2], lane_cand[3]);
    end
  end

  // final compare and index rebuild
  assign fin      = pick(e_lo_r, e_hi_r);
  assign idx_wide = {{INDEX_BITS{1'b0}}, fin.blk, fin.lane};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && e_valid_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && e_valid_r) begin
      if (fin.fill) begin
        out_index_r <= idx_wide[INDEX_BITS-1:0];
        out_x_r     <= fin.x;
        out_y_r     <= fin.y;
        out_z_r     <= fin.z;
      end else begin
        out_index_r <= '0;
        out_x_r     <= '0;
        out_y_r     <= '0;
        out_z_r     <= '0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.best_index = out_index_r;
  assign out_ch.best_x     = out_x_r;
  assign out_ch.best_y     = out_y_r;
  assign out_ch.best_z     = out_z_r;

  // counter stays within the vertex limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex counter past limit");

  // closing a query empties every lane
  a_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && c_valid_r && c_last_r) |=> (lane_fill_r == '0))
    else $error("lanes not cleared at end of query");

  // a waiting result blocks new requests only while the next one is ready
  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && e_valid_r) |-> !in_ch.ready)
    else $error("request taken while result would be lost");

  // a query with a filled lane yields a filled winner
  a_winner: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && d_valid_r && (d_fill_r != '0)) |=> (e_lo_r.fill || e_hi_r.fill))
    else $error("winner lost in pair compare");

  // a result only follows a closed query
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(e_valid_r))
    else $error("result without closed query");

endmodule
